// File: src/assert_macros.svh
// Assertion macros for the port-level checker in src/bdb_checker.sv.
// Depends on a clock named clk and an active-high reset named rst in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property, sampled on clk, off during reset
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_PROP(lbl, !(expr), msg)

`endif

// File: src/bdb_pkg.sv
// Shared constants, widths and helper functions of the orbit histogram.
// No dependencies; used by the interfaces, the top level and the checker.
package bdb_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_MAX_ITERS  = 4096;
  localparam int DEF_COUNT_BITS = 24;

  localparam int FRAC = 28;

  localparam int ITERS_W = 13;
  localparam int ZOOM_W  = 16;
  localparam int DIM_W   = 9;
  localparam int INV_W   = 17;
  localparam int COORD_W = 8;
  localparam int HITS_W  = 13;
  localparam int RGBA_W  = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITERS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_LOG2  = 3'd4;

  localparam logic REQ_ACCUM = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  localparam logic [ITERS_W-1:0] RST_MAX_ITERS = 13'd256;
  localparam logic [ZOOM_W-1:0]  RST_ZOOM      = 16'd4096;
  localparam logic [DIM_W-1:0]   RST_WIDTH     = 9'd256;
  localparam logic [DIM_W-1:0]   RST_HEIGHT    = 9'd256;
  localparam logic [INV_W-1:0]   RST_INV_LOG2  = 17'd8192;

  localparam logic [7:0] END_R = 8'd255;
  localparam logic [7:0] END_G = 8'd105;
  localparam logic [7:0] END_B = 8'd180;
  localparam logic [7:0] ALPHA = 8'd255;

  // ceil(2^20 / 3): exact floor division by three for values below 2^19
  localparam logic [32:0] RECIP3     = 33'd349526;
  localparam int          RECIP3_SH  = 20;
  localparam int          ZOOM_FRAC  = 12;

  // 2.0 and 1.5 in Q4.28, and the escape bound 4 in Q8.56
  localparam logic signed [33:0] OFF_RE   = 34'sh020000000;
  localparam logic signed [33:0] OFF_IM   = 34'sh018000000;
  localparam logic [63:0]        ESC_BOUND = 64'h0400_0000_0000_0000;

  function automatic logic signed [31:0] sat_q(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -66'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [7:0] colour_chan(input logic [63:0] p, input logic [7:0] e);
    logic [63:0] v;
    v = (p * 64'(e)) >> 16;
    return (v > 64'd255) ? 8'hFF : v[7:0];
  endfunction

endpackage

// File: src/bdb_if.sv
// Valid/ready channel interfaces: request, response and register write.
// Depends on bdb_pkg for field widths.
interface bdb_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [bdb_pkg::COORD_W-1:0] col_index;
  logic [bdb_pkg::COORD_W-1:0] row_index;
  modport source (output valid, req_type, col_index, row_index, input ready);
  modport sink   (input valid, req_type, col_index, row_index, output ready);
endinterface

interface bdb_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       escaped;
  logic [bdb_pkg::HITS_W-1:0] cells_hit;
  logic [bdb_pkg::RGBA_W-1:0] rgba;
  modport source (output valid, escaped, cells_hit, rgba, input ready);
  modport sink   (input valid, escaped, cells_hit, rgba, output ready);
endinterface

interface bdb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bdb_pkg::CFG_IDX_W-1:0]  index;
  logic [bdb_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/buddhabrot_orbit_histogram.sv
// Top level of the orbit histogram: sequencer, shared multiplier, divider and heatmap memory.
// Depends on bdb_pkg and the channel interfaces in bdb_if.sv.
//
// One word is taken at a time. After reset the heatmap is swept to zero, one entry a cycle,
// and no request is taken until the sweep ends. A read fetches the count, scales it by
// inv_log2 in the multiplier and forms the colour. An accumulate finds the start point by two
// bit-serial divisions, runs the escape test over the orbit and, if it escapes, replays the
// orbit, where the orbit arithmetic and the cell mapping share one 33x33 multiplier and each
// hit is a read-modify-write of the heatmap, which has one read port and one write port.
// The response register lets a new request in while a result waits.
module buddhabrot_orbit_histogram #(
  parameter int MAX_WIDTH  = bdb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bdb_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_ITERS  = bdb_pkg::DEF_MAX_ITERS,
  parameter int COUNT_BITS = bdb_pkg::DEF_COUNT_BITS
) (
  input  logic      clk,
  input  logic      rst,
  bdb_req_if.sink   req,
  bdb_rsp_if.source rsp,
  bdb_cfg_if.sink   cfg
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int SZW   = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);
  localparam int NW    = $clog2(MAX_ITERS + 1);
  localparam int T1W   = SZW + 4;
  localparam int PW    = T1W + 4;
  localparam int DNW   = 10 + bdb_pkg::FRAC;
  localparam int DCW   = $clog2(DNW);
  localparam int RECIP3_SH_C = bdb_pkg::RECIP3_SH;
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RD_MUL, S_RD_COL, S_DIV_RE, S_DIV_IM, S_START,
    S_XX, S_YY, S_CHK, S_XY, S_UPD,
    S_C_SX, S_C_SY, S_C_ZX, S_C_ZY, S_C_DX, S_C_DY, S_C_RD, S_C_WR, S_DONE
  } state_t;

  state_t state;

  logic [bdb_pkg::ITERS_W-1:0] max_iters;
  logic [bdb_pkg::ZOOM_W-1:0]  zoom;
  logic [bdb_pkg::DIM_W-1:0]   width;
  logic [bdb_pkg::DIM_W-1:0]   height;
  logic [bdb_pkg::INV_W-1:0]   inv_log2;

  logic [AW-1:0]               clr_addr;
  logic [bdb_pkg::COORD_W-1:0] row;
  logic                        rd_ok;
  logic [DNW-1:0]              div_num;
  logic [DNW-1:0]              div_q;
  logic [SZW-1:0]              div_rem;
  logic [DCW-1:0]              div_cnt;
  logic signed [31:0]          a, b, x, y;
  logic [63:0]                 xx;
  logic [63:0]                 diff;
  logic signed [65:0]          prod;
  logic                        fresh, replay, esc;
  logic [NW-1:0]               steps;
  logic [bdb_pkg::HITS_W-1:0]  hits;
  logic                        sneg_x, sneg_y;
  logic [T1W-1:0]              t1x, t1y;
  logic [PW-1:0]               px, py, tx;
  logic [AW-1:0]               cell_addr;
  logic [bdb_pkg::RGBA_W-1:0]  rgba_r;

  logic                        out_valid;
  logic                        out_escaped;
  logic [bdb_pkg::HITS_W-1:0]  out_hits;
  logic [bdb_pkg::RGBA_W-1:0]  out_rgba;

  logic [COUNT_BITS-1:0] heat [DEPTH];
  logic [COUNT_BITS-1:0] mem_rdata;
  logic                  mem_re, mem_we;
  logic [AW-1:0]         mem_raddr, mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;

  logic [SZW-1:0]     w_eff, h_eff, div_d;
  logic [NW-1:0]      n_eff;
  logic signed [32:0] mul_a, mul_b;
  logic [SZW:0]       rem_sh;
  logic               q_bit;
  logic [SZW-1:0]     rem_new;
  logic [DNW-1:0]     q_next;
  logic [65:0]        z3;
  logic signed [65:0] re_full, im_full;
  logic signed [33:0] sx, sy;
  logic [63:0]        mag;
  logic signed [65:0] dsh, xysh;
  logic [PW-1:0]      ty_c;
  logic               cell_ok;
  logic [AW-1:0]      cell_addr_c;
  logic [AW-1:0]      req_addr;
  logic               req_fire, load_out;
  logic [9:0]         col3, row3;
  logic [COUNT_BITS-1:0] rd_cnt;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign req_fire  = req.valid && req.ready;
  assign load_out  = (state == S_DONE) && (!out_valid || rsp.ready);

  assign rsp.valid     = out_valid;
  assign rsp.escaped   = out_escaped;
  assign rsp.cells_hit = out_hits;
  assign rsp.rgba      = out_rgba;

  always_comb begin
    if (width == '0) begin
      w_eff = SZW'(1);
    end else if (32'(width) > MAX_WIDTH) begin
      w_eff = SZW'(MAX_WIDTH);
    end else begin
      w_eff = SZW'(width);
    end
    if (height == '0) begin
      h_eff = SZW'(1);
    end else if (32'(height) > MAX_HEIGHT) begin
      h_eff = SZW'(MAX_HEIGHT);
    end else begin
      h_eff = SZW'(height);
    end
    if (32'(max_iters) > MAX_ITERS) begin
      n_eff = NW'(MAX_ITERS);
    end else begin
      n_eff = NW'(max_iters);
    end
  end

  // bit-serial restoring division of the start point
  assign col3    = ({2'b00, req.col_index} << 1) + {2'b00, req.col_index};
  assign row3    = ({2'b00, row} << 1) + {2'b00, row};
  assign div_d   = (state == S_DIV_RE) ? w_eff : h_eff;
  assign rem_sh  = {div_rem, div_num[DNW-1]};
  assign q_bit   = (rem_sh >= {1'b0, div_d});
  assign rem_new = q_bit ? SZW'(rem_sh - {1'b0, div_d}) : SZW'(rem_sh);
  assign q_next  = {div_q[DNW-2:0], q_bit};
  assign z3      = (66'(zoom) << 1) + 66'(zoom);
  assign re_full = $signed(66'(q_next)) - $signed(66'(zoom) << 17);
  assign im_full = $signed(z3 << 15) - $signed(66'(q_next));

  // orbit arithmetic
  assign mag  = xx + prod[63:0];
  assign dsh  = $signed({{2{diff[63]}}, diff}) >>> bdb_pkg::FRAC;
  assign xysh = prod >>> (bdb_pkg::FRAC - 1);
  assign sx   = $signed({{2{x[31]}}, x}) + bdb_pkg::OFF_RE;
  assign sy   = $signed({{2{y[31]}}, y}) + bdb_pkg::OFF_IM;

  // cell mapping
  assign ty_c    = prod[RECIP3_SH_C +: PW];
  assign cell_ok = !sneg_x && !sneg_y && (tx < PW'(w_eff)) && (ty_c < PW'(h_eff));
  assign cell_addr_c = AW'(32'(ty_c) * 32'(MAX_WIDTH) + 32'(tx));
  assign req_addr    = AW'(32'(req.row_index) * 32'(MAX_WIDTH) + 32'(req.col_index));
  assign rd_cnt      = rd_ok ? mem_rdata : '0;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_XX:     begin mul_a = {x[31], x};   mul_b = {x[31], x};   end
      S_YY:     begin mul_a = {y[31], y};   mul_b = {y[31], y};   end
      S_XY:     begin mul_a = {x[31], x};   mul_b = {y[31], y};   end
      S_C_SX:   begin mul_a = sx[32:0];     mul_b = 33'(w_eff);   end
      S_C_SY:   begin mul_a = sy[32:0];     mul_b = 33'(h_eff);   end
      S_C_ZX:   begin mul_a = 33'(t1x);     mul_b = 33'(zoom);    end
      S_C_ZY:   begin mul_a = 33'(t1y);     mul_b = 33'(zoom);    end
      S_C_DX:   begin mul_a = 33'(px);      mul_b = bdb_pkg::RECIP3; end
      S_C_DY:   begin mul_a = 33'(py);      mul_b = bdb_pkg::RECIP3; end
      S_RD_MUL: begin mul_a = 33'(rd_cnt);  mul_b = 33'(inv_log2); end
      default:  begin mul_a = '0;           mul_b = '0;           end
    endcase
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = req_addr;
    mem_we    = 1'b0;
    mem_waddr = cell_addr;
    mem_wdata = mem_rdata + COUNT_BITS'(1);
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      S_IDLE: begin
        mem_re = req_fire && (req.req_type == bdb_pkg::REQ_READ);
      end
      S_C_RD: begin
        mem_re    = cell_ok;
        mem_raddr = cell_addr_c;
      end
      S_C_WR: begin
        mem_we = (mem_rdata != CMAX);
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      heat[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= heat[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      max_iters <= bdb_pkg::RST_MAX_ITERS;
      zoom      <= bdb_pkg::RST_ZOOM;
      width     <= bdb_pkg::RST_WIDTH;
      height    <= bdb_pkg::RST_HEIGHT;
      inv_log2  <= bdb_pkg::RST_INV_LOG2;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          bdb_pkg::REG_MAX_ITERS: max_iters <= cfg.data[bdb_pkg::ITERS_W-1:0];
          bdb_pkg::REG_ZOOM:      zoom      <= cfg.data[bdb_pkg::ZOOM_W-1:0];
          bdb_pkg::REG_WIDTH:     width     <= cfg.data[bdb_pkg::DIM_W-1:0];
          bdb_pkg::REG_HEIGHT:    height    <= cfg.data[bdb_pkg::DIM_W-1:0];
          bdb_pkg::REG_INV_LOG2:  inv_log2  <= cfg.data[bdb_pkg::INV_W-1:0];
          default:                ;
        endcase
      end

      if (load_out) begin
        out_valid   <= 1'b1;
        out_escaped <= esc;
        out_hits    <= hits;
        out_rgba    <= rgba_r;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_fire) begin
            esc    <= 1'b0;
            hits   <= '0;
            rgba_r <= '0;
            row    <= req.row_index;
            rd_ok  <= (32'(req.col_index) < MAX_WIDTH) && (32'(req.row_index) < MAX_HEIGHT);
            if (req.req_type == bdb_pkg::REQ_READ) begin
              state <= S_RD_MUL;
            end else begin
              div_num <= {col3, {bdb_pkg::FRAC{1'b0}}};
              div_rem <= '0;
              div_cnt <= '0;
              replay  <= 1'b0;
              state   <= S_DIV_RE;
            end
          end
        end
        S_RD_MUL: begin
          state <= S_RD_COL;
        end
        S_RD_COL: begin
          rgba_r <= {bdb_pkg::colour_chan(prod[63:0], bdb_pkg::END_R),
                     bdb_pkg::colour_chan(prod[63:0], bdb_pkg::END_G),
                     bdb_pkg::colour_chan(prod[63:0], bdb_pkg::END_B),
                     bdb_pkg::ALPHA};
          state  <= S_DONE;
        end
        S_DIV_RE, S_DIV_IM: begin
          div_num <= div_num << 1;
          div_rem <= rem_new;
          div_q   <= q_next;
          div_cnt <= div_cnt + DCW'(1);
          if (div_cnt == DCW'(DNW - 1)) begin
            div_cnt <= '0;
            div_rem <= '0;
            if (state == S_DIV_RE) begin
              a       <= bdb_pkg::sat_q(re_full);
              div_num <= {row3, {bdb_pkg::FRAC{1'b0}}};
              state   <= S_DIV_IM;
            end else begin
              b     <= bdb_pkg::sat_q(im_full);
              state <= S_START;
            end
          end
        end
        S_START: begin
          x     <= a;
          y     <= b;
          fresh <= 1'b1;
          steps <= '0;
          state <= (n_eff == '0) ? S_DONE : S_XX;
        end
        S_XX: begin
          state <= S_YY;
        end
        S_YY: begin
          xx    <= prod[63:0];
          state <= S_CHK;
        end
        S_CHK: begin
          diff <= xx - prod[63:0];
          if (!fresh && (mag > bdb_pkg::ESC_BOUND)) begin
            if (!replay) begin
              esc    <= 1'b1;
              replay <= 1'b1;
              state  <= S_START;
            end else begin
              state <= S_DONE;
            end
          end else if (!fresh && replay) begin
            state <= S_C_SX;
          end else if (steps == n_eff) begin
            state <= S_DONE;
          end else begin
            state <= S_XY;
          end
        end
        S_XY: begin
          state <= S_UPD;
        end
        S_UPD: begin
          x     <= bdb_pkg::sat_q(dsh + {{34{a[31]}}, a});
          y     <= bdb_pkg::sat_q(xysh + {{34{b[31]}}, b});
          steps <= steps + NW'(1);
          fresh <= 1'b0;
          state <= S_XX;
        end
        S_C_SX: begin
          sneg_x <= sx[33];
          state  <= S_C_SY;
        end
        S_C_SY: begin
          t1x    <= prod[bdb_pkg::FRAC +: T1W];
          sneg_y <= sy[33];
          state  <= S_C_ZX;
        end
        S_C_ZX: begin
          t1y   <= prod[bdb_pkg::FRAC +: T1W];
          state <= S_C_ZY;
        end
        S_C_ZY: begin
          px    <= prod[bdb_pkg::ZOOM_FRAC +: PW];
          state <= S_C_DX;
        end
        S_C_DX: begin
          py    <= prod[bdb_pkg::ZOOM_FRAC +: PW];
          state <= S_C_DY;
        end
        S_C_DY: begin
          tx    <= prod[RECIP3_SH_C +: PW];
          state <= S_C_RD;
        end
        S_C_RD: begin
          cell_addr <= cell_addr_c;
          if (cell_ok) begin
            state <= S_C_WR;
          end else begin
            state <= (steps == n_eff) ? S_DONE : S_XY;
          end
        end
        S_C_WR: begin
          if (mem_rdata != CMAX) begin
            hits <= hits + bdb_pkg::HITS_W'(1);
          end
          state <= (steps == n_eff) ? S_DONE : S_XY;
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/bdb_checker.sv
// Port-level checks on the orbit histogram, attached to the top level by bind.
// Depends on bdb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bdb_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic                       rsp_escaped,
  input logic [bdb_pkg::HITS_W-1:0] rsp_cells_hit,
  input logic [bdb_pkg::RGBA_W-1:0] rsp_rgba
);

  `ASSERT_PROP(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "response word dropped")
  `ASSERT_PROP(a_busy_after_req, req_valid && req_ready |=> !req_ready, "second word taken")
  `ASSERT_NEVER(a_no_hits_unless_escaped, rsp_valid && !rsp_escaped && rsp_cells_hit != '0, "hits without escape")
  `ASSERT_NEVER(a_read_alpha, rsp_valid && rsp_rgba != '0 && (rsp_rgba[7:0] != bdb_pkg::ALPHA || rsp_escaped), "bad read word")

endmodule

bind buddhabrot_orbit_histogram bdb_checker u_bdb_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_escaped   (rsp.escaped),
  .rsp_cells_hit (rsp.cells_hit),
  .rsp_rgba      (rsp.rgba)
);

// File: sim/bdb_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the orbit histogram: watches the request, response and register channels,
// predicts each response from its own copy of the heatmap and registers, and counts mismatches.
// Depends on bdb_pkg and the channel interfaces in bdb_if.sv.
module bdb_scoreboard (
  input  logic clk,
  input  logic rst,
  bdb_req_if   req,
  bdb_rsp_if   rsp,
  bdb_cfg_if   cfg,
  output int   errors,
  output int   pending,
  output int   n_accum,
  output int   n_reads,
  output int   n_escapes
);

  typedef struct {
    logic                       escaped;
    logic [bdb_pkg::HITS_W-1:0] cells_hit;
    logic [bdb_pkg::RGBA_W-1:0] rgba;
  } orbit_result_t;

  localparam longint Q_HI = 64'sd2147483647;
  localparam longint Q_LO = -64'sd2147483648;
  localparam int     CELLS = bdb_pkg::DEF_MAX_WIDTH * bdb_pkg::DEF_MAX_HEIGHT;

  logic [bdb_pkg::DEF_COUNT_BITS-1:0] heat [CELLS];
  logic [bdb_pkg::ITERS_W-1:0] iters_reg;
  logic [bdb_pkg::ZOOM_W-1:0]  zoom_reg;
  logic [bdb_pkg::DIM_W-1:0]   width_reg;
  logic [bdb_pkg::DIM_W-1:0]   height_reg;
  logic [bdb_pkg::INV_W-1:0]   inv_reg;
  orbit_result_t               awaited [$];

  function automatic longint clamp_q(longint v);
    if (v > Q_HI) return Q_HI;
    if (v < Q_LO) return Q_LO;
    return v;
  endfunction

  function automatic bit orbit_next(inout longint x, inout longint y, input longint a,
                                    input longint b);
    longint nx, ny;
    longint unsigned mag;
    nx = clamp_q(((x * x - y * y) >>> bdb_pkg::FRAC) + a);
    ny = clamp_q(((x * y) >>> (bdb_pkg::FRAC - 1)) + b);
    x = nx;
    y = ny;
    mag = longint'(nx * nx) + longint'(ny * ny);
    return mag > (64'd4 << (2 * bdb_pkg::FRAC));
  endfunction

  function automatic int cell_of(longint v, longint off, int size);
    longint s, t1, t;
    s = v + off;
    if (s < 0) return -1;
    t1 = (s * size) >>> bdb_pkg::FRAC;
    t = (t1 * longint'(zoom_reg)) / 12288;
    if (t >= size) return -1;
    return int'(t);
  endfunction

  function automatic logic [7:0] shade(longint e, longint cnt);
    longint v;
    v = (e * cnt * longint'(inv_reg)) >>> 16;
    return (v > 255) ? 8'hFF : v[7:0];
  endfunction

  function automatic orbit_result_t predict_word(logic kind, int col, int row);
    orbit_result_t r;
    int w, h, n, hits, tx, ty;
    longint a, b, x, y, cnt;
    bit esc;
    r = '{escaped: 1'b0, cells_hit: '0, rgba: '0};
    if (kind == bdb_pkg::REQ_READ) begin
      cnt = heat[row * bdb_pkg::DEF_MAX_WIDTH + col];
      r.rgba = {shade(bdb_pkg::END_R, cnt), shade(bdb_pkg::END_G, cnt),
                shade(bdb_pkg::END_B, cnt), bdb_pkg::ALPHA};
      return r;
    end
    w = (width_reg == 0) ? 1 :
        (width_reg > bdb_pkg::DEF_MAX_WIDTH) ? bdb_pkg::DEF_MAX_WIDTH : width_reg;
    h = (height_reg == 0) ? 1 :
        (height_reg > bdb_pkg::DEF_MAX_HEIGHT) ? bdb_pkg::DEF_MAX_HEIGHT : height_reg;
    n = (iters_reg > bdb_pkg::DEF_MAX_ITERS) ? bdb_pkg::DEF_MAX_ITERS : iters_reg;
    a = clamp_q(((longint'(col) * 3) <<< bdb_pkg::FRAC) / w - (longint'(zoom_reg) <<< 17));
    b = clamp_q(-(((longint'(row) * 3) <<< bdb_pkg::FRAC) / h)
                + ((longint'(zoom_reg) * 3) <<< 15));
    x = a;
    y = b;
    esc = 0;
    hits = 0;
    for (int i = 0; i < n && !esc; i++) esc = orbit_next(x, y, a, b);
    if (esc) begin
      x = a;
      y = b;
      for (int i = 0; i < n; i++) begin
        if (orbit_next(x, y, a, b)) break;
        tx = cell_of(x, 64'sd2 <<< bdb_pkg::FRAC, w);
        ty = cell_of(y, 64'sd3 <<< (bdb_pkg::FRAC - 1), h);
        if (tx >= 0 && ty >= 0 && heat[ty * bdb_pkg::DEF_MAX_WIDTH + tx] != '1) begin
          heat[ty * bdb_pkg::DEF_MAX_WIDTH + tx]++;
          hits++;
        end
      end
    end
    r.escaped = esc;
    r.cells_hit = hits[bdb_pkg::HITS_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    orbit_result_t want;
    if (rst) begin
      iters_reg  <= bdb_pkg::RST_MAX_ITERS;
      zoom_reg   <= bdb_pkg::RST_ZOOM;
      width_reg  <= bdb_pkg::RST_WIDTH;
      height_reg <= bdb_pkg::RST_HEIGHT;
      inv_reg    <= bdb_pkg::RST_INV_LOG2;
      awaited.delete();
      for (int i = 0; i < CELLS; i++) heat[i] = '0;
      errors = 0;
      n_accum = 0;
      n_reads = 0;
      n_escapes = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          bdb_pkg::REG_MAX_ITERS: iters_reg  <= cfg.data[bdb_pkg::ITERS_W-1:0];
          bdb_pkg::REG_ZOOM:      zoom_reg   <= cfg.data[bdb_pkg::ZOOM_W-1:0];
          bdb_pkg::REG_WIDTH:     width_reg  <= cfg.data[bdb_pkg::DIM_W-1:0];
          bdb_pkg::REG_HEIGHT:    height_reg <= cfg.data[bdb_pkg::DIM_W-1:0];
          bdb_pkg::REG_INV_LOG2:  inv_reg    <= cfg.data[bdb_pkg::INV_W-1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        awaited.push_back(predict_word(req.req_type, req.col_index, req.row_index));
        if (req.req_type == bdb_pkg::REQ_READ) n_reads++;
        else n_accum++;
      end
      if (rsp.valid && rsp.ready) begin
        if (awaited.size() == 0) begin
          $error("response word with nothing awaited");
          errors++;
        end else begin
          want = awaited.pop_front();
          if (want.escaped) n_escapes++;
          if (rsp.escaped !== want.escaped) begin
            $error("escaped: expected %0d, got %0d", want.escaped, rsp.escaped);
            errors++;
          end
          if (rsp.cells_hit !== want.cells_hit) begin
            $error("cells_hit: expected %0d, got %0d", want.cells_hit, rsp.cells_hit);
            errors++;
          end
          if (rsp.rgba !== want.rgba) begin
            $error("rgba: expected %08h, got %08h", want.rgba, rsp.rgba);
            errors++;
          end
        end
      end
    end
    pending = awaited.size();
  end
endmodule

// File: sim/buddhabrot_orbit_histogram_tb.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the orbit histogram: directed words, then three random phases with
// varied registers, two under back-pressure. Depends on bdb_pkg, bdb_if.sv, block, bdb_checker.
module buddhabrot_orbit_histogram_tb;

  localparam logic [bdb_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [bdb_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic clk;
  logic rst;
  int   send_idle;
  int   recv_idle;
  int   errors, pending, n_accum, n_reads, n_escapes;
  int   w_use, h_use;

  bdb_req_if req_ch ();
  bdb_rsp_if rsp_ch ();
  bdb_cfg_if cfg_ch ();

  buddhabrot_orbit_histogram DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  bdb_scoreboard u_scoreboard (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg       (cfg_ch),
    .errors    (errors),
    .pending   (pending),
    .n_accum   (n_accum),
    .n_reads   (n_reads),
    .n_escapes (n_escapes)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("buddhabrot_orbit_histogram test failed");
    $finish;
  end

  always @(negedge clk) begin
    rsp_ch.ready = ($urandom_range(99) >= recv_idle);
  end

  task automatic send_word(logic kind, int col, int row);
    while ($urandom_range(99) < send_idle) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid     = 1'b1;
    req_ch.req_type  = kind;
    req_ch.col_index = col[bdb_pkg::COORD_W-1:0];
    req_ch.row_index = row[bdb_pkg::COORD_W-1:0];
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // hold off until every awaited response is back
  task automatic drain();
    req_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [bdb_pkg::CFG_IDX_W-1:0] idx, int value);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value[bdb_pkg::CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_regs(int iters, int zoom, int w, int h, int inv);
    write_reg(bdb_pkg::REG_MAX_ITERS, iters);
    write_reg(bdb_pkg::REG_ZOOM, zoom);
    write_reg(bdb_pkg::REG_WIDTH, w);
    write_reg(bdb_pkg::REG_HEIGHT, h);
    write_reg(bdb_pkg::REG_INV_LOG2, inv);
    w_use = (w == 0) ? 1 : (w > 256) ? 256 : w;
    h_use = (h == 0) ? 1 : (h > 256) ? 256 : h;
  endtask

  initial begin
    rst = 1'b1;
    send_idle = 29;
    recv_idle = 62;
    req_ch.valid = 1'b0;
    req_ch.req_type = bdb_pkg::REQ_ACCUM;
    req_ch.col_index = '0;
    req_ch.row_index = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = bdb_pkg::REG_MAX_ITERS;
    cfg_ch.data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    set_regs(32, 4096, 16, 16, 65536);
    send_word(bdb_pkg::REQ_ACCUM, 0, 0);
    send_word(bdb_pkg::REQ_ACCUM, 255, 255);
    send_word(bdb_pkg::REQ_ACCUM, 0, 255);
    send_word(bdb_pkg::REQ_ACCUM, 255, 0);
    send_word(bdb_pkg::REQ_ACCUM, 8, 8);
    send_word(bdb_pkg::REQ_ACCUM, 4, 5);
    send_word(bdb_pkg::REQ_ACCUM, 10, 3);
    send_word(bdb_pkg::REQ_READ, 0, 0);
    send_word(bdb_pkg::REQ_READ, 255, 255);
    send_word(bdb_pkg::REQ_READ, 8, 8);
    send_word(bdb_pkg::REQ_READ, 3, 12);
    drain();
    write_reg(bdb_pkg::REG_MAX_ITERS, 0);
    send_word(bdb_pkg::REQ_ACCUM, 5, 5);
    send_word(bdb_pkg::REQ_READ, 5, 5);
    drain();
    write_reg(bdb_pkg::REG_MAX_ITERS, 8191);
    send_word(bdb_pkg::REQ_ACCUM, 9, 7);
    drain();
    set_regs(16, 4096, 0, 511, 131071);
    send_word(bdb_pkg::REQ_ACCUM, 0, 0);
    send_word(bdb_pkg::REQ_ACCUM, 200, 100);
    send_word(bdb_pkg::REQ_READ, 0, 40);
    drain();
    write_reg(REG_SPARE_LO, 3);
    write_reg(REG_SPARE_HI, 131071);
    set_regs(20, 0, 16, 16, 0);
    send_word(bdb_pkg::REQ_ACCUM, 3, 3);
    send_word(bdb_pkg::REQ_READ, 0, 0);
    drain();
    write_reg(bdb_pkg::REG_ZOOM, 65535);
    send_word(bdb_pkg::REQ_ACCUM, 7, 7);
    send_word(bdb_pkg::REQ_READ, 0, 1);
    drain();

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: set_regs(24, 4096, 32, 24, 30000);
        1: set_regs($urandom_range(64, 16), $urandom_range(6000, 3000),
                    $urandom_range(64, 8), $urandom_range(64, 8), $urandom_range(131071));
        default: set_regs(40, 4096, 256, 256, 65536);
      endcase
      send_idle = (p == 0) ? 29 : (p == 1) ? 62 : 0;
      recv_idle = (p == 0) ? 62 : (p == 1) ? 29 : 0;
      for (int k = 0; k < 26; k++) begin
        if ($urandom_range(99) < 15)
          send_word(1'($urandom_range(1)), $urandom_range(255), $urandom_range(255));
        else if ($urandom_range(99) < 60)
          send_word(bdb_pkg::REQ_ACCUM, $urandom_range(w_use - 1), $urandom_range(h_use - 1));
        else
          send_word(bdb_pkg::REQ_READ, $urandom_range(w_use - 1), $urandom_range(h_use - 1));
        if (k == 12) drain();
      end
      drain();
    end

    $display("covered %0d accumulate words (%0d escaped) and %0d colour reads",
             n_accum, n_escapes, n_reads);
    $display("registers swept through zero, extreme and random settings under back-pressure");
    if (errors == 0) begin
      $display("buddhabrot_orbit_histogram test passed");
    end else begin
      $display("buddhabrot_orbit_histogram test failed");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+src
src/bdb_pkg.sv
src/bdb_if.sv
src/buddhabrot_orbit_histogram.sv
src/bdb_checker.sv
sim/bdb_checker.sv
sim/buddhabrot_orbit_histogram_tb.sv
